/* rtl/lpht_pkg.sv */
// Shared types, constants and codes for the linear probing hash table.
package lpht_pkg;

    localparam int SLOTS      = 128;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int KEY_W      = 21;
    localparam int VAL_W      = 64;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 7;
    localparam int HASH_W     = 32;
    localparam int FOLD_SHIFT = 16;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [HASH_W-1:0] HASH_MULT = 32'h9E37_79B9;

    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ZERO_KEY = 3'd5;

    typedef enum logic [1:0] {
        OP_LOOKUP,
        OP_INSERT,
        OP_ZERO
    } op_t;

    typedef enum logic {
        BK_IDLE,
        BK_PROBE
    } bk_state_t;

    typedef struct packed {
        op_t               op;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [SLOT_W-1:0] home;
    } req_t;

endpackage

/* rtl/lpht_front.sv */
// Front end: request capture, classification and home slot hashing.
module lpht_front
    import lpht_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             kind,
    input  logic [KEY_W-1:0] key,
    input  logic [VAL_W-1:0] value,
    output logic             busy,
    input  logic             q_full,
    output logic             push,
    output req_t             push_data
);

    logic              stage_valid_reg;
    logic              stage_valid_next;
    op_t               op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [HASH_W-1:0] prod_reg;
    logic [HASH_W-1:0] fold;
    logic              accept;
    op_t               op_class;

    assign busy   = stage_valid_reg && q_full;
    assign push   = stage_valid_reg && !q_full;
    assign accept = start && !busy;

    always_comb
    begin
        if (key == '0)
        begin
            op_class = OP_ZERO;
        end
        else if (kind)
        begin
            op_class = OP_INSERT;
        end
        else
        begin
            op_class = OP_LOOKUP;
        end
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // product kept mod 2^32
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_class;
            key_reg   <= key;
            value_reg <= value;
            prod_reg  <= HASH_W'({{(HASH_W - KEY_W){1'b0}}, key} * HASH_MULT);
        end
    end

    assign fold = prod_reg ^ (prod_reg >> FOLD_SHIFT);

    always_comb
    begin
        push_data.op    = op_reg;
        push_data.key   = key_reg;
        push_data.value = value_reg;
        push_data.home  = fold[SLOT_W-1:0];
    end

endmodule

/* rtl/lpht_queue.sv */
// Short request queue between front end and probe engine.
module lpht_queue
    import lpht_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t push_data,
    output logic full,
    input  logic pop,
    output req_t head,
    output logic empty
);

    req_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full    = cnt_reg == QCNT_W'(QDEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/lpht_back.sv */
// Probe engine: slot stores, linear probe walk, writes and result register.
module lpht_back
    import lpht_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  req_t                  q_head,
    output logic                  pop,
    output logic                  done,
    output logic [STATUS_W-1:0]   status,
    output logic [VAL_W-1:0]      found_value,
    output logic [SLOT_OUT_W-1:0] slot
);

    bk_state_t             state_reg;
    bk_state_t             state_next;
    req_t                  req_reg;
    req_t                  req_next;
    logic [SLOT_W-1:0]     idx_reg;
    logic [SLOT_W-1:0]     idx_next;
    logic [SLOT_W-1:0]     cnt_reg;
    logic [SLOT_W-1:0]     cnt_next;
    logic [CNT_W-1:0]      entry_cnt_reg;
    logic [CNT_W-1:0]      entry_cnt_next;
    logic [SLOTS-1:0]      valid_reg;
    logic [KEY_W-1:0]      key_mem [SLOTS];
    logic [VAL_W-1:0]      val_mem [SLOTS];
    logic [KEY_W-1:0]      key_rd_reg;
    logic                  vld_rd_reg;
    logic [VAL_W-1:0]      val_rd_reg;
    logic                  wr_en;
    logic                  done_reg;
    logic                  done_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic [VAL_W-1:0]      found_reg;
    logic [VAL_W-1:0]      found_next;
    logic [SLOT_OUT_W-1:0] slot_reg;
    logic [SLOT_OUT_W-1:0] slot_next;
    logic [KEY_W-1:0]      key_seen;
    logic                  hit_empty;
    logic                  hit_match;
    logic                  last;

    assign pop       = (state_reg == BK_IDLE) && !q_empty;
    assign key_seen  = vld_rd_reg ? key_rd_reg : '0;
    assign hit_empty = key_seen == '0;
    assign hit_match = key_seen == req_reg.key;
    assign last      = cnt_reg == SLOT_W'(SLOTS - 1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (pop && q_head.op != OP_ZERO)
                begin
                    state_next = BK_PROBE;
                end
            end
            BK_PROBE:
            begin
                if (hit_empty || hit_match || last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_next       = req_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        entry_cnt_next = entry_cnt_reg;
        wr_en          = 1'b0;
        done_next      = 1'b0;
        status_next    = status_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (pop)
                begin
                    req_next = q_head;
                    idx_next = q_head.home;
                    cnt_next = '0;
                    if (q_head.op == OP_ZERO)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_ZERO_KEY;
                        found_next  = '0;
                        slot_next   = '0;
                    end
                end
            end
            BK_PROBE:
            begin
                if (hit_empty || hit_match)
                begin
                    done_next  = 1'b1;
                    slot_next  = SLOT_OUT_W'(idx_reg);
                    found_next = '0;
                    if (req_reg.op == OP_LOOKUP)
                    begin
                        if (hit_match && !hit_empty)
                        begin
                            status_next = ST_FOUND;
                            found_next  = val_rd_reg;
                        end
                        else
                        begin
                            status_next = ST_MISS;
                        end
                    end
                    else if (!hit_empty)
                    begin
                        status_next = ST_UPDATED;
                        wr_en       = 1'b1;
                    end
                    else if (entry_cnt_reg >= CNT_W'(SLOTS))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        status_next    = ST_INSERTED;
                        wr_en          = 1'b1;
                        entry_cnt_next = entry_cnt_reg + 1'b1;
                    end
                end
                else if (last)
                begin
                    done_next   = 1'b1;
                    slot_next   = SLOT_OUT_W'(idx_reg);
                    found_next  = '0;
                    status_next = (req_reg.op == OP_LOOKUP) ? ST_MISS : ST_FULL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            entry_cnt_reg <= '0;
            valid_reg     <= '0;
            vld_rd_reg    <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            entry_cnt_reg <= entry_cnt_next;
            vld_rd_reg    <= valid_reg[idx_next];
            done_reg      <= done_next;
            if (wr_en)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        slot_reg   <= slot_next;
    end

    // read port follows the probe index; data lines up with idx_reg
    always_ff @(posedge clk)
    begin
        key_rd_reg <= key_mem[idx_next];
        val_rd_reg <= val_mem[idx_next];
        if (wr_en)
        begin
            key_mem[idx_reg] <= req_reg.key;
            val_mem[idx_reg] <= req_reg.value;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign found_value = found_reg;
    assign slot        = slot_reg;

endmodule

/* rtl/linear_probe_hash_table_top.sv */
// Top level of the linear probing hash table.
//
// Command port: start with kind, key and value is a transfer when busy is low.
// kind 0 looks a key up, kind 1 inserts or updates its 64-bit record.
// Result port: done is high for one cycle with status, found_value and slot.
// Every request gives exactly one result, in request order.
// A request passes the hashing stage register and the queue; the probe
// engine then reads its home slot and walks on slot by slot until a slot is
// empty or matches, or every slot was seen, and registers the result.
// The probe engine takes one request at a time and reads one slot of the
// key/record stores per cycle.
// Zero keys are answered without probing. A two-entry queue lets the front
// take new requests while the engine probes; busy rises when the queue is
// full and the hashing stage still holds a request.
// Reset clears every slot (per-slot valid flags) and the entry count at once;
// no sweep is needed. The receiver cannot stall: results are never held.
module linear_probe_hash_table_top
    import lpht_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  kind,
    input  logic [KEY_W-1:0]      key,
    input  logic [VAL_W-1:0]      value,
    output logic                  done,
    output logic [STATUS_W-1:0]   status,
    output logic [VAL_W-1:0]      found_value,
    output logic [SLOT_OUT_W-1:0] slot
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    req_t push_data;
    req_t q_head;

    lpht_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .kind      (kind),
        .key       (key),
        .value     (value),
        .busy      (busy),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    lpht_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    lpht_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .pop         (pop),
        .done        (done),
        .status      (status),
        .found_value (found_value),
        .slot        (slot)
    );

`ifndef ASSERT_OFF
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= ST_ZERO_KEY))
        else $error("status code out of range");

    a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_ZERO_KEY) |-> (found_value == '0 && slot == '0))
        else $error("zero key result carries data");

    a_value_only_found: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_FOUND) |-> (found_value == '0))
        else $error("record returned without a hit");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(!rst_n) && !$past(start)) |-> !done)
        else $error("result without a request");
`endif

endmodule

/* test/testbench.sv */
// Self-checking testbench for the linear probing hash table: directed and random traffic, scored per transfer.
module testbench;
    import lpht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;
    localparam int   POOL_SIZE   = 220;
    localparam int   DRAIN       = 40;
    localparam int   MAX_CYCLES  = 1_000_000;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } table_request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [VAL_W-1:0]      found_value;
        logic [SLOT_OUT_W-1:0] slot;
    } table_reply_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  kind = KIND_LOOKUP;
    logic [KEY_W-1:0]      key = '0;
    logic [VAL_W-1:0]      value = '0;
    logic                  busy;
    logic                  done;
    logic [STATUS_W-1:0]   status;
    logic [VAL_W-1:0]      found_value;
    logic [SLOT_OUT_W-1:0] slot;

    // model of the table contents
    logic [KEY_W-1:0] key_mem [SLOTS];
    logic [VAL_W-1:0] record_mem [SLOTS];
    int               fill_count = 0;

    table_request_t request_q [$];
    table_reply_t   reply_q [$];
    int             fails = 0;
    int             cycle_count = 0;
    int             idle_left = 0;
    int             burst_left = 0;

    linear_probe_hash_table_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .key         (key),
        .value       (value),
        .done        (done),
        .status      (status),
        .found_value (found_value),
        .slot        (slot)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [SLOT_W-1:0] home_of(input logic [KEY_W-1:0] k);
        logic [HASH_W-1:0] h;
        h = k * HASH_MULT;
        h = h ^ (h >> FOLD_SHIFT);
        return h[SLOT_W-1:0];
    endfunction

    function automatic table_reply_t apply_request(input logic op_kind,
                                                   input logic [KEY_W-1:0] k,
                                                   input logic [VAL_W-1:0] v);
        table_reply_t      r;
        logic [SLOT_W-1:0] idx;
        bit                stopped;
        int                n;
        r = '0;
        if (k == '0)
        begin
            r.status = ST_ZERO_KEY;
            return r;
        end
        idx = home_of(k);
        stopped = 1'b0;
        n = 0;
        while (!stopped && n < SLOTS)
        begin
            if (key_mem[idx] == '0 || key_mem[idx] == k)
                stopped = 1'b1;
            else if (n != SLOTS - 1)
                idx = idx + 1'b1;
            n++;
        end
        r.slot = idx;
        if (op_kind == KIND_LOOKUP)
        begin
            if (stopped && key_mem[idx] != '0)
            begin
                r.status      = ST_FOUND;
                r.found_value = record_mem[idx];
            end
            else
                r.status = ST_MISS;
        end
        else if (!stopped)
            r.status = ST_FULL;
        else if (key_mem[idx] != '0)
        begin
            record_mem[idx] = v;
            r.status        = ST_UPDATED;
        end
        else if (fill_count >= SLOTS)
            r.status = ST_FULL;
        else
        begin
            key_mem[idx]    = k;
            record_mem[idx] = v;
            fill_count++;
            r.status = ST_INSERTED;
        end
        return r;
    endfunction

    function automatic int pick_idle();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_request(input logic k_op, input logic [KEY_W-1:0] k,
                                input logic [VAL_W-1:0] v);
        table_request_t req;
        req.kind  = k_op;
        req.key   = k;
        req.value = v;
        request_q.push_back(req);
    endtask

    // driver: a transfer happens on an edge where start is high and busy low
    always @(posedge clk)
    begin
        table_request_t req;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                reply_q.push_back(apply_request(kind, key, value));
                idle_left = pick_idle();
            end
            if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
            end
            else if (request_q.size() != 0)
            begin
                req = request_q.pop_front();
                kind  <= req.kind;
                key   <= req.key;
                value <= req.value;
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        table_reply_t want;
        if (rst_n && done)
        begin
            if (reply_q.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result: status %0d value %h slot %0d",
                             status, found_value, slot);
            end
            else
            begin
                want = reply_q.pop_front();
                if (status !== want.status || found_value !== want.found_value ||
                    slot !== want.slot)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("mismatch: exp status %0d value %h slot %0d, got status %0d value %h slot %0d",
                                 want.status, want.found_value, want.slot,
                                 status, found_value, slot);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [KEY_W-1:0] pool [POOL_SIZE];
        logic [KEY_W-1:0] chain_a, chain_b, chain_c, wrap_a, wrap_b, k;
        int               pick, ins_pct, span;
        logic             op;

        foreach (key_mem[i])
            key_mem[i] = '0;

        // keys sharing the home slot of key 1, and keys whose home is the last slot
        k = 21'd2;
        chain_a = '0;
        chain_b = '0;
        chain_c = '0;
        while (chain_c == '0)
        begin
            if (home_of(k) == home_of(21'd1))
            begin
                if (chain_a == '0)
                    chain_a = k;
                else if (chain_b == '0)
                    chain_b = k;
                else
                    chain_c = k;
            end
            k = k + 1'b1;
        end
        wrap_a = '0;
        wrap_b = '0;
        k = 21'h1FFFFE;
        while (wrap_b == '0)
        begin
            if (home_of(k) == SLOT_W'(SLOTS - 1))
            begin
                if (wrap_a == '0)
                    wrap_a = k;
                else
                    wrap_b = k;
            end
            k = k - 1'b1;
        end

        push_request(KIND_LOOKUP, '0, '1);
        push_request(KIND_INSERT, '0, '1);
        push_request(KIND_LOOKUP, '1, '0);
        push_request(KIND_INSERT, '1, '1);
        push_request(KIND_LOOKUP, '1, '0);
        push_request(KIND_INSERT, '1, '0);
        push_request(KIND_LOOKUP, '1, '1);
        push_request(KIND_INSERT, 21'd1, 64'hA5A5_5A5A_F00F_0FF0);
        push_request(KIND_INSERT, chain_a, 64'h0123_4567_89AB_CDEF);
        push_request(KIND_INSERT, chain_b, 64'hFEDC_BA98_7654_3210);
        push_request(KIND_LOOKUP, chain_b, '0);
        push_request(KIND_LOOKUP, chain_c, '0);
        push_request(KIND_INSERT, chain_a, 64'h8000_0000_0000_0001);
        push_request(KIND_LOOKUP, chain_a, '0);
        push_request(KIND_LOOKUP, 21'd1, '0);
        push_request(KIND_INSERT, wrap_a, 64'h5555_5555_5555_5555);
        push_request(KIND_INSERT, wrap_b, 64'hAAAA_AAAA_AAAA_AAAA);
        push_request(KIND_LOOKUP, wrap_b, '0);
        push_request(KIND_LOOKUP, wrap_a, '0);

        foreach (pool[i])
            pool[i] = KEY_W'($urandom_range(1, (1 << KEY_W) - 1));

        // partial fill with a small key set, then a wider set that fills the table
        for (int n = 0; n < 1150; n++)
        begin
            span    = (n < 600) ? 100 : POOL_SIZE;
            ins_pct = (n < 600) ? 55 : 60;
            pick    = $urandom_range(0, 99);
            if (pick < 3)
                k = '0;
            else if (pick < 10)
                k = KEY_W'($urandom_range(1, (1 << KEY_W) - 1));
            else
                k = pool[$urandom_range(0, span - 1)];
            op = ($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_LOOKUP;
            push_request(op, k, {$urandom, $urandom});
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (request_q.size() != 0 || start || reply_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(posedge clk);
        fails += reply_q.size();

        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
